[rtl/mhfbq_pkg.sv]
// Shared types and constants for the free-block min-heap queue.
// Used by mhfbq_ctrl, mhfbq_out, the top level and the testbench; depends on nothing.
`default_nettype none

package mhfbq_pkg;

  // Storage geometry
  localparam int HEAP_DEPTH   = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int HANDLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(HEAP_DEPTH);
  localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W      = IDX_W + 2;

  // Fixed stream field widths
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEL_LAST,
    S_DEL_LOAD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD_L,
    S_DN_RD_R,
    S_DN_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    key;
    logic [HANDLE_WIDTH-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t                 status;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [KEY_WIDTH-1:0]    size;
    logic [CNT_W-1:0]        count;
  } res_t;

endpackage

`default_nettype wire

[rtl/mhfbq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module mhfbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds last data when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/mhfbq_ctrl.sv]
// Heap sequencer: insert with sift up, remove with sift down then sift up.
// Drives the entry RAM through a hole-based walk; uses mhfbq_pkg.
`default_nettype none

module mhfbq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mhfbq_pkg::op_t     in_op,
  input  wire logic [mhfbq_pkg::HANDLE_WIDTH-1:0] in_handle,
  input  wire logic [mhfbq_pkg::KEY_WIDTH-1:0]    in_size,
  input  wire logic [mhfbq_pkg::POS_W-1:0]        in_pos,
  output mhfbq_pkg::mem_req_t     mem_req,
  input  wire mhfbq_pkg::entry_t  rd_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output mhfbq_pkg::res_t         res
);

  localparam int IDX_W   = mhfbq_pkg::IDX_W;
  localparam int CNT_W   = mhfbq_pkg::CNT_W;
  localparam int CHILD_W = mhfbq_pkg::CHILD_W;

  mhfbq_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  mhfbq_pkg::entry_t         mov_r, mov_nxt;
  mhfbq_pkg::entry_t         lch_r, lch_nxt;
  mhfbq_pkg::status_t        stat_r, stat_nxt;
  mhfbq_pkg::entry_t         rem_r, rem_nxt;

  logic                      accept;
  logic                      heap_full;
  logic                      pos_bad;
  logic [IDX_W-1:0]          last_idx;
  logic [IDX_W-1:0]          parent_idx;
  logic [CHILD_W-1:0]        lchild;
  logic [CHILD_W-1:0]        rchild;
  logic                      has_l;
  logic                      has_r;
  logic                      parent_gt;
  logic                      dn_stop;
  logic                      pick_left;

  // Index arithmetic and key compares
  assign accept     = in_valid && (state_r == mhfbq_pkg::S_IDLE);
  assign heap_full  = (cnt_r == CNT_W'(mhfbq_pkg::HEAP_DEPTH));
  assign pos_bad    = (CNT_W'(in_pos) >= cnt_r);
  assign last_idx   = IDX_W'(cnt_r - CNT_W'(1));
  assign parent_idx = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign lchild     = {1'b0, pos_r, 1'b1};
  assign rchild     = lchild + CHILD_W'(1);
  assign has_l      = (lchild < CHILD_W'(cnt_r));
  assign has_r      = (rchild < CHILD_W'(cnt_r));
  assign parent_gt  = (rd_data.key > mov_r.key);
  assign dn_stop    = (mov_r.key <= lch_r.key) && (!has_r || (mov_r.key <= rd_data.key));
  assign pick_left  = !has_r || (lch_r.key < rd_data.key);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mhfbq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_op == mhfbq_pkg::OP_INSERT) begin
            state_nxt = heap_full ? mhfbq_pkg::S_DONE : mhfbq_pkg::S_UP_RD;
          end else begin
            state_nxt = pos_bad ? mhfbq_pkg::S_DONE : mhfbq_pkg::S_DEL_LAST;
          end
        end
      end
      mhfbq_pkg::S_DEL_LAST: state_nxt = mhfbq_pkg::S_DEL_LOAD;
      mhfbq_pkg::S_DEL_LOAD: begin
        state_nxt = (pos_r == last_idx) ? mhfbq_pkg::S_DONE : mhfbq_pkg::S_DN_RD_L;
      end
      mhfbq_pkg::S_UP_RD: begin
        state_nxt = (pos_r == '0) ? mhfbq_pkg::S_DONE : mhfbq_pkg::S_UP_CMP;
      end
      mhfbq_pkg::S_UP_CMP: begin
        state_nxt = parent_gt ? mhfbq_pkg::S_UP_RD : mhfbq_pkg::S_DONE;
      end
      mhfbq_pkg::S_DN_RD_L: begin
        state_nxt = has_l ? mhfbq_pkg::S_DN_RD_R : mhfbq_pkg::S_UP_RD;
      end
      mhfbq_pkg::S_DN_RD_R: state_nxt = mhfbq_pkg::S_DN_CMP;
      mhfbq_pkg::S_DN_CMP: begin
        state_nxt = dn_stop ? mhfbq_pkg::S_UP_RD : mhfbq_pkg::S_DN_RD_L;
      end
      mhfbq_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = mhfbq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mhfbq_pkg::S_IDLE;
    endcase
  end

  // Memory requests and handshake outputs
  always_comb begin
    mem_req           = '0;
    mem_req.wr_data   = mov_r;
    mem_req.wr_addr   = pos_r;
    in_ready          = (state_r == mhfbq_pkg::S_IDLE);
    res_valid         = (state_r == mhfbq_pkg::S_DONE);
    case (state_r)
      mhfbq_pkg::S_IDLE: begin
        mem_req.rd_en   = accept && (in_op == mhfbq_pkg::OP_REMOVE) && !pos_bad;
        mem_req.rd_addr = IDX_W'(in_pos);
      end
      mhfbq_pkg::S_DEL_LAST: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = last_idx;
      end
      mhfbq_pkg::S_UP_RD: begin
        // At the root, drop the moving entry into the hole
        mem_req.rd_en   = (pos_r != '0);
        mem_req.rd_addr = parent_idx;
        mem_req.wr_en   = (pos_r == '0);
      end
      mhfbq_pkg::S_UP_CMP: begin
        // Pull the parent down, or settle the moving entry
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = parent_gt ? rd_data : mov_r;
      end
      mhfbq_pkg::S_DN_RD_L: begin
        mem_req.rd_en   = has_l;
        mem_req.rd_addr = IDX_W'(lchild);
      end
      mhfbq_pkg::S_DN_RD_R: begin
        mem_req.rd_en   = has_r;
        mem_req.rd_addr = IDX_W'(rchild);
      end
      mhfbq_pkg::S_DN_CMP: begin
        // Lift the smaller child into the hole
        mem_req.wr_en   = !dn_stop;
        mem_req.wr_data = pick_left ? lch_r : rd_data;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    mov_nxt  = mov_r;
    lch_nxt  = lch_r;
    stat_nxt = stat_r;
    rem_nxt  = rem_r;
    case (state_r)
      mhfbq_pkg::S_IDLE: begin
        if (accept) begin
          rem_nxt = '0;
          pos_nxt = IDX_W'(in_pos);
          if (in_op == mhfbq_pkg::OP_INSERT) begin
            if (heap_full) begin
              stat_nxt = mhfbq_pkg::STAT_FULL;
            end else begin
              stat_nxt       = mhfbq_pkg::STAT_OK;
              mov_nxt.key    = in_size;
              mov_nxt.handle = in_handle;
              pos_nxt        = IDX_W'(cnt_r);
              cnt_nxt        = cnt_r + CNT_W'(1);
            end
          end else begin
            stat_nxt = pos_bad ? mhfbq_pkg::STAT_RANGE : mhfbq_pkg::STAT_OK;
          end
        end
      end
      mhfbq_pkg::S_DEL_LAST: rem_nxt = rd_data;
      mhfbq_pkg::S_DEL_LOAD: begin
        mov_nxt = rd_data;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      mhfbq_pkg::S_UP_CMP: begin
        if (parent_gt) begin
          pos_nxt = parent_idx;
        end
      end
      mhfbq_pkg::S_DN_RD_R: lch_nxt = rd_data;
      mhfbq_pkg::S_DN_CMP: begin
        if (!dn_stop) begin
          pos_nxt = pick_left ? IDX_W'(lchild) : IDX_W'(rchild);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhfbq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    mov_r  <= mov_nxt;
    lch_r  <= lch_nxt;
    stat_r <= stat_nxt;
    rem_r  <= rem_nxt;
  end

  assign res.status = stat_r;
  assign res.handle = rem_r.handle;
  assign res.size   = rem_r.key;
  assign res.count  = cnt_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(mhfbq_pkg::HEAP_DEPTH))
    else $error("entry count above capacity");

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("read and write issued in the same cycle");

  a_hole_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mhfbq_pkg::S_UP_RD || state_r == mhfbq_pkg::S_UP_CMP ||
     state_r == mhfbq_pkg::S_DN_RD_L || state_r == mhfbq_pkg::S_DN_RD_R ||
     state_r == mhfbq_pkg::S_DN_CMP) |-> (CNT_W'(pos_r) < cnt_r))
    else $error("hole position outside the heap");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == mhfbq_pkg::OP_INSERT && !heap_full)
      |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the heap by one");
`endif

endmodule

`default_nettype wire

[rtl/mhfbq_out.sv]
// Result register stage: holds one finished result for the master stream.
// Uses mhfbq_pkg for the result record.
`default_nettype none

module mhfbq_out (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            res_valid,
  output logic                 res_ready,
  input  wire mhfbq_pkg::res_t res,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [63:0]          out_tdata
);

  logic            out_valid_r, out_valid_nxt;
  mhfbq_pkg::res_t out_res_r;

  // Load when the slot is empty or draining this cycle
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_ready ? res_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  // Pack fields, lowest first
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.count, out_res_r.size,
                       out_res_r.handle, out_res_r.status};

endmodule

`default_nettype wire

[rtl/min_heap_free_block_queue_top.sv]
// Free-block priority queue: a binary min-heap of block handles keyed by size,
// 64 entries held in one single-port-style RAM, one request in flight at a
// time. An insert climbs from the new tail slot toward the root. A remove of
// the last entry only reads it out; any other remove refills the hole with the
// last entry, sinks it level by level until it finds no child or stays below
// its children, then climbs it toward the root. A full, empty or out-of-range
// request goes straight to its result. In every case the result shows on the
// output in the same cycle as the next request can be taken. The entry RAM
// allows one access a cycle with registered read data, so each heap level costs
// a parent read and a compare for sift up and two child reads and a compare
// for sift down. One finished result is held in an output register, so a new
// request is taken while it waits.
// Uses mhfbq_pkg, mhfbq_ctrl, mhfbq_ram and mhfbq_out.
`default_nettype none

module min_heap_free_block_queue_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[0], block_handle[16:1], block_size[48:17], remove_position[54:49]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], removed_handle[17:2], removed_size[49:18], entry_count[56:50]
  output logic [63:0]      out_tdata
);

  mhfbq_pkg::mem_req_t mem_req;
  mhfbq_pkg::entry_t   rd_data;
  logic [$bits(mhfbq_pkg::entry_t)-1:0] rd_word;
  logic                res_valid;
  logic                res_ready;
  mhfbq_pkg::res_t     res;
  mhfbq_pkg::op_t      in_op;

  // Unpack the request
  assign in_op   = mhfbq_pkg::op_t'(in_tdata[0]);
  assign rd_data = mhfbq_pkg::entry_t'(rd_word);

  mhfbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_op),
    .in_handle (in_tdata[16:1]),
    .in_size   (in_tdata[48:17]),
    .in_pos    (in_tdata[54:49]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mhfbq_ram #(
    .WIDTH ($bits(mhfbq_pkg::entry_t)),
    .DEPTH (mhfbq_pkg::HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_word)
  );

  mhfbq_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[bench/min_heap_free_block_queue_top_test.sv]
// Testbench for the free-block min-heap queue: directed and random insert and
// remove requests on the input stream, each reply checked against a local heap
// predictor. Depends on mhfbq_pkg and min_heap_free_block_queue_top.
`timescale 1ns / 100ps

module min_heap_free_block_queue_top_test;
  import mhfbq_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  // Idling control shared by both sides
  int gap_pct;
  int stall_pct;
  bit quiet;

  int mismatch_count = 0;
  int cycle_count = 0;

  // Predictor state: a mirror of the heap storage and its fill level
  logic [KEY_WIDTH-1:0]    heap_key_mirror    [HEAP_DEPTH];
  logic [HANDLE_WIDTH-1:0] heap_handle_mirror [HEAP_DEPTH];
  int                      heap_fill;

  // Replies predicted but not yet seen on the output stream
  res_t pending_replies [$];

  min_heap_free_block_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------

  function automatic void mirror_swap(int a, int b);
    logic [KEY_WIDTH-1:0]    k;
    logic [HANDLE_WIDTH-1:0] h;
    k = heap_key_mirror[a];
    h = heap_handle_mirror[a];
    heap_key_mirror[a]    = heap_key_mirror[b];
    heap_handle_mirror[a] = heap_handle_mirror[b];
    heap_key_mirror[b]    = k;
    heap_handle_mirror[b] = h;
  endfunction

  // Climb while the parent is strictly larger
  function automatic void mirror_rise(int pos);
    int parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_key_mirror[parent] <= heap_key_mirror[pos]) break;
      mirror_swap(parent, pos);
      pos = parent;
    end
  endfunction

  // Sink toward the smaller child, right child on a tie; return final slot
  function automatic int mirror_sink(int pos);
    int                   lc;
    int                   rc;
    int                   pick;
    logic [KEY_WIDTH-1:0] cur;
    while (pos < heap_fill) begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      if (lc >= heap_fill) break;
      cur = heap_key_mirror[pos];
      if (cur <= heap_key_mirror[lc] && (rc >= heap_fill || cur <= heap_key_mirror[rc])) break;
      if (rc >= heap_fill || heap_key_mirror[lc] < heap_key_mirror[rc]) pick = lc;
      else pick = rc;
      mirror_swap(pos, pick);
      pos = pick;
    end
    return pos;
  endfunction

  function automatic res_t predict_reply(op_t op, logic [HANDLE_WIDTH-1:0] handle,
                                         logic [KEY_WIDTH-1:0] size, logic [POS_W-1:0] pos);
    res_t r;
    int   slot;
    r.status = STAT_OK;
    r.handle = '0;
    r.size   = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        heap_key_mirror[heap_fill]    = size;
        heap_handle_mirror[heap_fill] = handle;
        mirror_rise(heap_fill);
        heap_fill++;
      end
    end else begin
      slot = int'(pos);
      if (heap_fill == 0 || slot >= heap_fill) begin
        r.status = STAT_RANGE;
      end else begin
        r.handle = heap_handle_mirror[slot];
        r.size   = heap_key_mirror[slot];
        heap_fill--;
        // Refill the hole from the last entry and restore order both ways
        if (slot != heap_fill) begin
          heap_key_mirror[slot]    = heap_key_mirror[heap_fill];
          heap_handle_mirror[slot] = heap_handle_mirror[heap_fill];
          slot = mirror_sink(slot);
          mirror_rise(slot);
        end
      end
    end
    r.count = heap_fill[CNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream drivers and reply checker
  // ---------------------------------------------------------------------------

  // Send one request; called right after a rising edge
  task automatic send_request(op_t op, logic [HANDLE_WIDTH-1:0] handle,
                              logic [KEY_WIDTH-1:0] size, logic [POS_W-1:0] pos);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pos, size, handle, op};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(predict_reply(op, handle, size, pos));
  endtask

  task automatic insert_block(logic [HANDLE_WIDTH-1:0] handle, logic [KEY_WIDTH-1:0] size);
    send_request(OP_INSERT, handle, size, POS_W'($urandom_range(0, 63)));
  endtask

  task automatic remove_at(int pos);
    send_request(OP_REMOVE, HANDLE_WIDTH'($urandom_range(0, 65535)), KEY_WIDTH'($urandom),
                 POS_W'(pos));
  endtask

  // Output back-pressure in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compare each reply with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[1:0]);
      got.handle = out_tdata[17:2];
      got.size   = out_tdata[49:18];
      got.count  = out_tdata[56:50];
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d count %0d", got.status, got.count);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.handle != want.handle) begin
          $error("removed_handle: expected 0x%0h, actual 0x%0h", want.handle, got.handle);
          mismatch_count++;
        end
        if (got.size != want.size) begin
          $error("removed_size: expected 0x%0h, actual 0x%0h", want.size, got.size);
          mismatch_count++;
        end
        if (got.count != want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, got.count);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pick a size key: narrow range for ties, full range, or edge values
  function automatic logic [KEY_WIDTH-1:0] pick_size(int mode);
    logic [KEY_WIDTH-1:0] s;
    case (mode)
      0: s = KEY_WIDTH'($urandom_range(0, 7));
      1: s = KEY_WIDTH'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          2: s = 32'h7fff_ffff;
          default: s = 32'h8000_0000;
        endcase
      end
    endcase
    return s;
  endfunction

  // Remove requests against an empty heap and past the fill level, and one insert and its removal
  task automatic test_empty_and_range();
    gap_pct   = 20;
    stall_pct = 20;
    remove_at(0);
    remove_at(63);
    insert_block(16'h00a5, 32'd1000);
    remove_at(1);
    remove_at(63);
    remove_at(0);
  endtask

  // Edge keys and handles, equal keys, removal at root, middle, tail and past the fill level
  task automatic test_keys_and_ties();
    insert_block(16'hffff, 32'hffff_ffff);
    insert_block(16'h0000, 32'h0000_0000);
    insert_block(16'h1111, 32'd100);
    insert_block(16'h2222, 32'd100);
    insert_block(16'h3333, 32'd100);
    insert_block(16'h4444, 32'd50);
    insert_block(16'h5555, 32'd100);
    insert_block(16'h8001, 32'h8000_0000);
    insert_block(16'h7ffe, 32'h7fff_ffff);
    remove_at(heap_fill - 1);
    remove_at(0);
    remove_at(2);
    remove_at(1);
    remove_at(heap_fill - 2);
    remove_at(0);
    remove_at(0);
    remove_at(heap_fill);
    remove_at(0);
    remove_at(0);
  endtask

  // Fill to capacity, hit the full case, then drain at random positions
  task automatic test_fill_and_drain();
    gap_pct   = 30;
    stall_pct = 30;
    while (heap_fill < HEAP_DEPTH)
      insert_block(HANDLE_WIDTH'($urandom_range(0, 65535)), pick_size($urandom_range(0, 2)));
    repeat (3)
      insert_block(HANDLE_WIDTH'($urandom_range(0, 65535)), pick_size(1));
    remove_at(63);
    remove_at(0);
    insert_block(16'hbeef, 32'd3);
    insert_block(16'hcafe, 32'd3);
    while (heap_fill > 0) begin
      if ($urandom_range(0, 15) == 0) remove_at($urandom_range(heap_fill, 63));
      else remove_at($urandom_range(0, heap_fill - 1));
    end
  endtask

  // Mixed traffic in phases of different insert bias and idling
  task automatic test_random_mix();
    int ins_pct;
    int key_mode;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0: ins_pct = 80;
        1: ins_pct = 25;
        default: ins_pct = 55;
      endcase
      case (phase)
        2, 5: begin gap_pct = 0;  stall_pct = 0;  end
        3:    begin gap_pct = 60; stall_pct = 10; end
        4:    begin gap_pct = 10; stall_pct = 60; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      // Run the last stretch without any idling
      if (phase == 8) quiet = 1'b1;
      repeat (100) begin
        key_mode = ($urandom_range(0, 9) < 4) ? 0 : (($urandom_range(0, 9) == 0) ? 2 : 1);
        if ($urandom_range(0, 99) < ins_pct)
          insert_block(HANDLE_WIDTH'($urandom_range(0, 65535)), pick_size(key_mode));
        else if (heap_fill > 0 && $urandom_range(0, 7) != 0)
          remove_at($urandom_range(0, heap_fill - 1));
        else
          remove_at($urandom_range(0, 63));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    quiet          = 1'b0;
    heap_fill      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_range();
    test_keys_and_ties();
    test_fill_and_drain();
    test_random_mix();

    // Let the last replies come out, then a little extra for strays
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_replies.size() != 0) begin
      $error("%0d predicted replies never arrived", pending_replies.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
